// File: rtl/ctss_pkg.sv
// ----------------------------------------------------------------------------
// ctss_pkg
// Shared types and constants of the curve trace sweep sequencer: request and
// reply codes, phase flags, scan channel table and controller states.
// ----------------------------------------------------------------------------
package ctss_pkg;

   localparam logic [1:0] REQ_START   = 2'd0;
   localparam logic [1:0] REQ_TIMEOUT = 2'd1;
   localparam logic [1:0] REQ_SAMPLE  = 2'd2;
   localparam logic [1:0] REQ_POLL    = 2'd3;

   localparam logic [1:0] REPLY_NONE   = 2'd0;
   localparam logic [1:0] REPLY_RECORD = 2'd1;
   localparam logic [1:0] REPLY_EMPTY  = 2'd2;

   localparam logic [1:0] CSR_POINT_COUNT = 2'd0;
   localparam logic [1:0] CSR_BIAS_VALUE  = 2'd1;
   localparam logic [1:0] CSR_POLARITY    = 2'd2;

   localparam logic [7:0] POINT_COUNT_RESET = 8'd16;
   localparam logic [7:0] DRIVE_MIN  = 8'd1;
   localparam logic [7:0] DRIVE_MAX  = 8'hFF;
   localparam logic [7:0] TAG_MARK   = 8'h80;
   localparam logic [8:0] BIAS_FULL  = 9'd256;
   localparam logic [8:0] DIV_DIVIDEND = 9'd256;
   localparam logic [3:0] DIV_LAST   = 4'd8;
   localparam logic [3:0] WAIT_FIRST = 4'd8;
   localparam logic [3:0] WAIT_NEXT  = 4'd4;
   localparam logic [3:0] WAIT_SCAN  = 4'd2;
   localparam logic [3:0] WAIT_NONE  = 4'd0;
   localparam logic [2:0] POLL_LIMIT = 3'd4;
   localparam logic [2:0] POLL_MAX   = 3'd7;
   localparam logic [2:0] ADC_NONE   = 3'd7;
   localparam logic [2:0] SLOT_LAST  = 3'd4;

   localparam int SCAN_SLOTS = 5;

   typedef struct packed {
      logic active;
      logic first;
      logic not_ready;
   } phase_type;

   localparam phase_type PHASE_IDLE = '{active: 1'b0, first: 1'b0, not_ready: 1'b0};
   localparam phase_type PHASE_NEW  = '{active: 1'b1, first: 1'b1, not_ready: 1'b1};

   typedef struct packed {
      logic [7:0] drive;
      logic [7:0] done;
      phase_type  phase;
      logic       restart;
      logic [3:0] tload;
   } np_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV  = 7'b0000010,
      ST_READ = 7'b0000100,
      ST_ACC  = 7'b0001000,
      ST_MUL  = 7'b0010000,
      ST_MEAN = 7'b0100000,
      ST_SEND = 7'b1000000
   } state_type;

   function automatic logic [2:0] slot_channel(input logic [2:0] slot);
      logic [2:0] chan;
      unique case (slot)
         3'd0:    chan = 3'd0;
         3'd1:    chan = 3'd1;
         3'd2:    chan = 3'd2;
         3'd3:    chan = 3'd3;
         default: chan = 3'd6;
      endcase
      return chan;
   endfunction

endpackage

// File: rtl/curve_trace_sweep_sequencer.sv
// ----------------------------------------------------------------------------
// curve_trace_sweep_sequencer
// Sweep sequencer for a transistor curve tracer: drive stepping, wait and
// scan control, sample storage in RAM and record generation on check polls.
// Timeout, sample and empty poll words give a registered result in the cycle
// after acceptance; start runs a 9-step restoring divider for the step. A
// record poll walks the sample RAM through read and accumulate states for each
// sample, then multiply and mean states for each scan slot, before it is sent.
// One word is processed at a time; synchronous reset clears control state,
// the sample RAM has no reset.
// ----------------------------------------------------------------------------
module curve_trace_sweep_sequencer #(
   parameter int SAMPLES_PER_POINT = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_sample,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_reply_kind,
   output logic [7:0] rsp_point_tag,
   output logic [7:0] rsp_collector_mean,
   output logic [7:0] rsp_current_mean,
   output logic [7:0] rsp_base_voltage,
   output logic [7:0] rsp_supply_mean,
   output logic [7:0] rsp_emitter_mean,
   output logic [7:0] rsp_drive_level,
   output logic [8:0] rsp_bias_level,
   output logic [3:0] rsp_timer_load,
   output logic [2:0] rsp_adc_request,
   output logic       rsp_busy_res,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);

   localparam int DEPTH       = ctss_pkg::SCAN_SLOTS * SAMPLES_PER_POINT;
   localparam int ADDR_W      = $clog2(DEPTH);
   localparam int PASS_W      = $clog2(SAMPLES_PER_POINT + 1);
   localparam int SUM_W       = $clog2(SAMPLES_PER_POINT * 255 + SAMPLES_PER_POINT / 2 + 1);
   localparam int RECIP_SHIFT = 18;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int RECIP_MULT  = ((1 << RECIP_SHIFT) + SAMPLES_PER_POINT - 1) / SAMPLES_PER_POINT;
   localparam int PROD_W      = SUM_W + RECIP_W;

   ctss_pkg::state_type state_ff, state_in;

   logic [7:0] point_count_ff, point_count_in;
   logic [7:0] bias_value_ff, bias_value_in;
   logic       polarity_ff, polarity_in;

   logic [PASS_W-1:0] pass_ff, pass_in;
   logic [2:0]        scan_ff, scan_in;
   logic [7:0]        done_ff, done_in;
   logic [7:0]        step_ff, step_in;
   logic [2:0]        poll_ff, poll_in;
   logic [7:0]        drive_ff, drive_in;
   logic [8:0]        bias_ff, bias_in;
   ctss_pkg::phase_type phase_ff, phase_in;

   logic [8:0] dvd_ff, dvd_in;
   logic [7:0] rem_ff, rem_in;
   logic [7:0] quo_ff, quo_in;
   logic [3:0] divcnt_ff, divcnt_in;

   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [2:0]        slot_ff, slot_in;
   logic [PASS_W-1:0] samp_ff, samp_in;
   logic [SUM_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [7:0]        mean_ff [ctss_pkg::SCAN_SLOTS];
   logic [7:0]        mean_in [ctss_pkg::SCAN_SLOTS];

   logic [1:0] pend_kind_ff, pend_kind_in;
   logic [7:0] pend_tag_ff, pend_tag_in;
   logic [3:0] pend_tload_ff, pend_tload_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_tag_ff, rsp_tag_in;
   logic [7:0] rsp_coll_ff, rsp_coll_in;
   logic [7:0] rsp_cur_ff, rsp_cur_in;
   logic [7:0] rsp_base_ff, rsp_base_in;
   logic [7:0] rsp_sup_ff, rsp_sup_in;
   logic [7:0] rsp_emit_ff, rsp_emit_in;
   logic [7:0] rsp_drive_ff, rsp_drive_in;
   logic [8:0] rsp_bias_ff, rsp_bias_in;
   logic [3:0] rsp_tload_ff, rsp_tload_in;
   logic [2:0] rsp_adc_ff, rsp_adc_in;
   logic       rsp_busy_ff, rsp_busy_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_rdata;

   logic rsp_hold;
   logic req_accept;

   function automatic ctss_pkg::np_type next_point(
      input logic [7:0] done,
      input logic [7:0] count,
      input logic [7:0] drive,
      input logic [7:0] step,
      input logic       pol,
      input logic [3:0] wait_ticks
   );
      ctss_pkg::np_type r;
      logic [8:0] up;
      r.drive   = drive;
      r.done    = 8'd0;
      r.phase   = ctss_pkg::PHASE_IDLE;
      r.restart = 1'b0;
      r.tload   = ctss_pkg::WAIT_NONE;
      up        = {1'b0, drive} + {1'b0, step};
      if (done < count) begin
         if (pol) begin
            r.drive = (drive <= step) ? ctss_pkg::DRIVE_MIN : drive - step;
         end else begin
            r.drive = up[8] ? ctss_pkg::DRIVE_MAX : up[7:0];
         end
         r.done    = done + 8'd1;
         r.phase   = ctss_pkg::PHASE_NEW;
         r.restart = 1'b1;
         r.tload   = wait_ticks;
      end
      return r;
   endfunction

   assign rsp_hold   = rsp_valid_ff && rsp_stall;
   assign req_stall  = (state_ff != ctss_pkg::ST_IDLE) || rsp_hold;
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   always_comb begin
      ctss_pkg::np_type np;
      logic             load;
      logic [1:0]       r_kind;
      logic [3:0]       r_tload;
      logic [2:0]       r_adc;
      logic [2:0]       slot;
      logic [PASS_W-1:0] pass_next;
      logic [8:0]       trial;
      logic             qbit;
      logic [7:0]       step_new;

      np        = '0;
      load      = 1'b0;
      r_kind    = ctss_pkg::REPLY_NONE;
      r_tload   = ctss_pkg::WAIT_NONE;
      r_adc     = ctss_pkg::ADC_NONE;
      slot      = (scan_ff <= ctss_pkg::SLOT_LAST) ? scan_ff : ctss_pkg::SLOT_LAST;
      pass_next = pass_ff + PASS_W'(1);
      trial     = {rem_ff, dvd_ff[8]};
      qbit      = trial >= {1'b0, point_count_ff};
      step_new  = (point_count_ff == 8'd0) ? 8'd0 : {quo_ff[6:0], qbit};

      state_in       = state_ff;
      point_count_in = point_count_ff;
      bias_value_in  = bias_value_ff;
      polarity_in    = polarity_ff;
      pass_in        = pass_ff;
      scan_in        = scan_ff;
      done_in        = done_ff;
      step_in        = step_ff;
      poll_in        = poll_ff;
      drive_in       = drive_ff;
      bias_in        = bias_ff;
      phase_in       = phase_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      divcnt_in      = divcnt_ff;
      rd_addr_in     = rd_addr_ff;
      slot_in        = slot_ff;
      samp_in        = samp_ff;
      acc_in         = acc_ff;
      prod_in        = prod_ff;
      mean_in        = mean_ff;
      pend_kind_in   = pend_kind_ff;
      pend_tag_in    = pend_tag_ff;
      pend_tload_in  = pend_tload_ff;
      ram_we         = 1'b0;
      ram_waddr      = ADDR_W'(ADDR_W'(slot) * ADDR_W'(SAMPLES_PER_POINT) + ADDR_W'(pass_ff));

      if (csr_valid) begin
         unique case (csr_index)
            ctss_pkg::CSR_POINT_COUNT: point_count_in = csr_data;
            ctss_pkg::CSR_BIAS_VALUE:  bias_value_in  = csr_data;
            ctss_pkg::CSR_POLARITY:    polarity_in    = csr_data[0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ctss_pkg::ST_IDLE: begin
            if (req_accept) begin
               unique case (req_type)
                  ctss_pkg::REQ_START: begin
                     if (polarity_ff) begin
                        drive_in = ctss_pkg::DRIVE_MAX;
                        bias_in  = ctss_pkg::BIAS_FULL - {1'b0, bias_value_ff};
                     end else begin
                        drive_in = ctss_pkg::DRIVE_MIN;
                        bias_in  = {1'b0, bias_value_ff};
                     end
                     done_in   = 8'd0;
                     dvd_in    = ctss_pkg::DIV_DIVIDEND;
                     rem_in    = 8'd0;
                     quo_in    = 8'd0;
                     divcnt_in = 4'd0;
                     state_in  = ctss_pkg::ST_DIV;
                  end
                  ctss_pkg::REQ_TIMEOUT: begin
                     load = 1'b1;
                     if (phase_ff.not_ready) begin
                        if (!phase_ff.first) begin
                           phase_in.not_ready = 1'b0;
                        end else begin
                           phase_in.first = 1'b0;
                           scan_in = 3'd0;
                           pass_in = '0;
                           r_tload = ctss_pkg::WAIT_SCAN;
                           r_adc   = ctss_pkg::slot_channel(3'd0);
                        end
                     end
                  end
                  ctss_pkg::REQ_SAMPLE: begin
                     load = 1'b1;
                     if (phase_ff.active && !phase_ff.first &&
                         pass_ff < PASS_W'(SAMPLES_PER_POINT)) begin
                        ram_we = 1'b1;
                        if (slot < ctss_pkg::SLOT_LAST) begin
                           scan_in = slot + 3'd1;
                           r_adc   = ctss_pkg::slot_channel(slot + 3'd1);
                        end else begin
                           pass_in = pass_next;
                           if (pass_next < PASS_W'(SAMPLES_PER_POINT)) begin
                              scan_in = 3'd0;
                              r_adc   = ctss_pkg::slot_channel(3'd0);
                           end else begin
                              phase_in.not_ready = 1'b0;
                           end
                        end
                     end
                  end
                  ctss_pkg::REQ_POLL: begin
                     poll_in = (poll_ff < ctss_pkg::POLL_MAX) ? poll_ff + 3'd1 : poll_ff;
                     if (!phase_ff.not_ready) begin
                        np = next_point(done_ff, point_count_ff, drive_ff, step_ff,
                                        polarity_ff, ctss_pkg::WAIT_NEXT);
                        pend_kind_in  = ctss_pkg::REPLY_RECORD;
                        pend_tag_in   = done_ff | ctss_pkg::TAG_MARK;
                        pend_tload_in = np.tload;
                        rd_addr_in    = '0;
                        slot_in       = 3'd0;
                        samp_in       = '0;
                        acc_in        = '0;
                        state_in      = ctss_pkg::ST_READ;
                     end else begin
                        load   = 1'b1;
                        r_kind = ctss_pkg::REPLY_EMPTY;
                        if (poll_in > ctss_pkg::POLL_LIMIT) begin
                           np = next_point(done_ff - 8'd1, point_count_ff, drive_ff,
                                           step_ff, polarity_ff, ctss_pkg::WAIT_NEXT);
                           poll_in = 3'd0;
                        end
                     end
                     if (!phase_ff.not_ready || poll_in == 3'd0) begin
                        drive_in = np.drive;
                        done_in  = np.done;
                        phase_in = np.phase;
                        r_tload  = np.tload;
                        if (np.restart) begin
                           poll_in = 3'd0;
                           pass_in = '0;
                        end
                     end
                  end
               endcase
            end
         end
         ctss_pkg::ST_DIV: begin
            dvd_in    = {dvd_ff[7:0], 1'b0};
            rem_in    = qbit ? 8'(trial - {1'b0, point_count_ff}) : trial[7:0];
            quo_in    = {quo_ff[6:0], qbit};
            divcnt_in = divcnt_ff + 4'd1;
            if (divcnt_ff == ctss_pkg::DIV_LAST) begin
               np = next_point(done_ff, point_count_ff, drive_ff, step_new,
                               polarity_ff, ctss_pkg::WAIT_FIRST);
               step_in       = step_new;
               drive_in      = np.drive;
               done_in       = np.done;
               phase_in      = np.phase;
               if (np.restart) begin
                  poll_in = 3'd0;
                  pass_in = '0;
               end
               pend_kind_in  = ctss_pkg::REPLY_NONE;
               pend_tag_in   = 8'd0;
               pend_tload_in = np.tload;
               state_in      = ctss_pkg::ST_SEND;
            end
         end
         ctss_pkg::ST_READ: begin
            state_in = ctss_pkg::ST_ACC;
         end
         ctss_pkg::ST_ACC: begin
            acc_in     = acc_ff + SUM_W'(ram_rdata);
            rd_addr_in = rd_addr_ff + ADDR_W'(1);
            if (samp_ff == PASS_W'(SAMPLES_PER_POINT - 1)) begin
               samp_in  = '0;
               state_in = ctss_pkg::ST_MUL;
            end else begin
               samp_in  = samp_ff + PASS_W'(1);
               state_in = ctss_pkg::ST_READ;
            end
         end
         ctss_pkg::ST_MUL: begin
            prod_in  = PROD_W'(acc_ff + SUM_W'(SAMPLES_PER_POINT / 2)) *
                       PROD_W'(RECIP_MULT);
            state_in = ctss_pkg::ST_MEAN;
         end
         ctss_pkg::ST_MEAN: begin
            mean_in[slot_ff] = prod_ff[RECIP_SHIFT +: 8];
            acc_in           = '0;
            if (slot_ff == ctss_pkg::SLOT_LAST) begin
               state_in = ctss_pkg::ST_SEND;
            end else begin
               slot_in  = slot_ff + 3'd1;
               state_in = ctss_pkg::ST_READ;
            end
         end
         ctss_pkg::ST_SEND: begin
            if (!rsp_hold) begin
               state_in = ctss_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctss_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = rsp_hold;
      rsp_kind_in  = rsp_kind_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_coll_in  = rsp_coll_ff;
      rsp_cur_in   = rsp_cur_ff;
      rsp_base_in  = rsp_base_ff;
      rsp_sup_in   = rsp_sup_ff;
      rsp_emit_in  = rsp_emit_ff;
      rsp_drive_in = rsp_drive_ff;
      rsp_bias_in  = rsp_bias_ff;
      rsp_tload_in = rsp_tload_ff;
      rsp_adc_in   = rsp_adc_ff;
      rsp_busy_in  = rsp_busy_ff;

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = r_kind;
         rsp_tag_in   = 8'd0;
         rsp_coll_in  = 8'd0;
         rsp_cur_in   = 8'd0;
         rsp_base_in  = 8'd0;
         rsp_sup_in   = 8'd0;
         rsp_emit_in  = 8'd0;
         rsp_drive_in = drive_in;
         rsp_bias_in  = bias_in;
         rsp_tload_in = r_tload;
         rsp_adc_in   = r_adc;
         rsp_busy_in  = phase_in.active;
      end else if (state_ff == ctss_pkg::ST_SEND && !rsp_hold) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = pend_kind_ff;
         rsp_tag_in   = pend_tag_ff;
         if (pend_kind_ff == ctss_pkg::REPLY_RECORD) begin
            rsp_coll_in = mean_ff[2];
            rsp_cur_in  = mean_ff[0];
            rsp_base_in = mean_ff[3] - mean_ff[1];
            rsp_sup_in  = mean_ff[4];
            rsp_emit_in = mean_ff[1];
         end else begin
            rsp_coll_in = 8'd0;
            rsp_cur_in  = 8'd0;
            rsp_base_in = 8'd0;
            rsp_sup_in  = 8'd0;
            rsp_emit_in = 8'd0;
         end
         rsp_drive_in = drive_ff;
         rsp_bias_in  = bias_ff;
         rsp_tload_in = pend_tload_ff;
         rsp_adc_in   = ctss_pkg::ADC_NONE;
         rsp_busy_in  = phase_ff.active;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ctss_pkg::ST_IDLE;
         point_count_ff <= ctss_pkg::POINT_COUNT_RESET;
         bias_value_ff  <= 8'd0;
         polarity_ff    <= 1'b0;
         pass_ff        <= '0;
         scan_ff        <= 3'd0;
         done_ff        <= 8'd0;
         step_ff        <= 8'd0;
         poll_ff        <= 3'd0;
         drive_ff       <= 8'd0;
         bias_ff        <= 9'd0;
         phase_ff       <= ctss_pkg::PHASE_IDLE;
         divcnt_ff      <= 4'd0;
         rd_addr_ff     <= '0;
         slot_ff        <= 3'd0;
         samp_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         point_count_ff <= point_count_in;
         bias_value_ff  <= bias_value_in;
         polarity_ff    <= polarity_in;
         pass_ff        <= pass_in;
         scan_ff        <= scan_in;
         done_ff        <= done_in;
         step_ff        <= step_in;
         poll_ff        <= poll_in;
         drive_ff       <= drive_in;
         bias_ff        <= bias_in;
         phase_ff       <= phase_in;
         divcnt_ff      <= divcnt_in;
         rd_addr_ff     <= rd_addr_in;
         slot_ff        <= slot_in;
         samp_ff        <= samp_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff        <= dvd_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      acc_ff        <= acc_in;
      prod_ff       <= prod_in;
      mean_ff       <= mean_in;
      pend_kind_ff  <= pend_kind_in;
      pend_tag_ff   <= pend_tag_in;
      pend_tload_ff <= pend_tload_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_coll_ff   <= rsp_coll_in;
      rsp_cur_ff    <= rsp_cur_in;
      rsp_base_ff   <= rsp_base_in;
      rsp_sup_ff    <= rsp_sup_in;
      rsp_emit_ff   <= rsp_emit_in;
      rsp_drive_ff  <= rsp_drive_in;
      rsp_bias_ff   <= rsp_bias_in;
      rsp_tload_ff  <= rsp_tload_in;
      rsp_adc_ff    <= rsp_adc_in;
      rsp_busy_ff   <= rsp_busy_in;
   end

   ctss_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_sample_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_sample),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_reply_kind     = rsp_kind_ff;
   assign rsp_point_tag      = rsp_tag_ff;
   assign rsp_collector_mean = rsp_coll_ff;
   assign rsp_current_mean   = rsp_cur_ff;
   assign rsp_base_voltage   = rsp_base_ff;
   assign rsp_supply_mean    = rsp_sup_ff;
   assign rsp_emitter_mean   = rsp_emit_ff;
   assign rsp_drive_level    = rsp_drive_ff;
   assign rsp_bias_level     = rsp_bias_ff;
   assign rsp_timer_load     = rsp_tload_ff;
   assign rsp_adc_request    = rsp_adc_ff;
   assign rsp_busy_res       = rsp_busy_ff;

`ifndef ASSERT_OFF
   a_state_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("controller state not one-hot");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == ctss_pkg::ST_IDLE))
      else $error("sample write during record readout");

   a_record_read: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_type == ctss_pkg::REQ_POLL && !phase_ff.not_ready)
      |=> (state_ff == ctss_pkg::ST_READ))
      else $error("ready poll did not start readout");

   a_pass_bound: assert property (@(posedge clock) disable iff (reset)
      pass_ff <= PASS_W'(SAMPLES_PER_POINT))
      else $error("scan pass index out of range");

   a_send_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ctss_pkg::ST_SEND && !rsp_hold) |=> rsp_valid_ff)
      else $error("pending result not delivered to output register");
`endif

endmodule

// File: rtl/ctss_ram.sv
// ----------------------------------------------------------------------------
// ctss_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ctss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
